FILE: rtl/irclp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the IRC line parser.
// No dependencies; imported by every module of the block.
package irclp_pkg;

   // Parser phases, one-hot.
   typedef enum logic [7:0] {
      PH_START   = 8'b0000_0001,
      PH_PING    = 8'b0000_0010,
      PH_SKIP    = 8'b0000_0100,
      PH_PREFIX  = 8'b0000_1000,
      PH_COMMAND = 8'b0001_0000,
      PH_TARGET  = 8'b0010_0000,
      PH_COLON   = 8'b0100_0000,
      PH_TEXT    = 8'b1000_0000
   } phase_type;

   // Prefix kinds
   localparam logic [1:0] PFX_NONE   = 2'd0;
   localparam logic [1:0] PFX_SERVER = 2'd1;
   localparam logic [1:0] PFX_USER   = 2'd2;

   // Command kinds
   localparam logic [3:0] CMD_UNKNOWN = 4'd0;
   localparam logic [3:0] CMD_NUMERIC = 4'd1;
   localparam logic [3:0] CMD_JOIN    = 4'd2;
   localparam logic [3:0] CMD_PART    = 4'd3;
   localparam logic [3:0] CMD_NICK    = 4'd4;
   localparam logic [3:0] CMD_KICK    = 4'd5;
   localparam logic [3:0] CMD_TOPIC   = 4'd6;
   localparam logic [3:0] CMD_NOTICE  = 4'd7;
   localparam logic [3:0] CMD_PRIVMSG = 4'd8;

   // Characters
   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_BANG  = 8'h21;  // '!'
   localparam logic [7:0] ASCII_AT    = 8'h40;  // '@'
   localparam logic [7:0] ASCII_COLON = 8'h3A;  // ':'
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_P     = 8'h50;
   localparam logic [7:0] ASCII_I     = 8'h49;
   localparam logic [7:0] ASCII_N     = 8'h4E;
   localparam logic [7:0] ASCII_G     = 8'h47;

   // PING is matched once this many characters agree
   localparam logic [2:0] PING_DONE = 3'd4;

   // Command words, first character in the low byte, zero padded to 7 bytes.
   localparam logic [55:0] WORD_JOIN    = 56'h0000004E494F4A;  // JOIN
   localparam logic [55:0] WORD_PART    = 56'h00000054524150;  // PART
   localparam logic [55:0] WORD_NICK    = 56'h0000004B43494E;  // NICK
   localparam logic [55:0] WORD_KICK    = 56'h0000004B43494B;  // KICK
   localparam logic [55:0] WORD_TOPIC   = 56'h00004349504F54;  // TOPIC
   localparam logic [55:0] WORD_NOTICE  = 56'h00454349544F4E;  // NOTICE
   localparam logic [55:0] WORD_PRIVMSG = 56'h47534D56495250;  // PRIVMSG

   localparam int CMD_BYTES = 7;

   // One parsed line record. Declared high field first so that the
   // flattened bits run prefix_kind upward from bit 0.
   typedef struct packed {
      logic       is_ping;
      logic [8:0] text_len;
      logic [8:0] text_start;
      logic [8:0] target_len;
      logic [8:0] target_start;
      logic [9:0] reply_code;
      logic [3:0] command_kind;
      logic [8:0] host_len;
      logic [8:0] user_len;
      logic [8:0] name_len;
      logic [1:0] prefix_kind;
   } rec_type;

endpackage

FILE: rtl/irclp_parser.sv
`timescale 1ns / 1ps
// Byte-at-a-time IRC line parser: phase machine, offset counters, command classifier.
// Depends on irclp_pkg.
module irclp_parser #(
   parameter int MAX_LINE = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output logic              rec_valid,
   output irclp_pkg::rec_type rec
);
   import irclp_pkg::*;

   localparam int POS_CAP_I = (MAX_LINE - 1 > 511) ? 511 : MAX_LINE - 1;
   localparam logic [8:0] POS_CAP = 9'(POS_CAP_I);

   phase_type   phase_ff, phase_in;
   logic [8:0]  line_pos_ff, line_pos_in;
   logic [8:0]  seg_ff, seg_in;
   logic [1:0]  pfx_ff, pfx_in;
   logic [8:0]  nick_ff, nick_in;
   logic [8:0]  user_ff, user_in;
   logic [8:0]  host_ff, host_in;
   logic [55:0] chars_ff, chars_in;
   logic [3:0]  count_ff, count_in;
   logic [3:0]  kind_ff, kind_in;
   logic [9:0]  numeric_ff, numeric_in;
   logic        param_ff, param_in;
   logic [8:0]  tgt_start_ff, tgt_start_in;
   logic [8:0]  tgt_len_ff, tgt_len_in;
   logic        cr_ff, cr_in;
   logic [2:0]  ping_ff, ping_in;

   logic [8:0]  pos, nxt, text_end;
   logic        lf_end, finish, emit, emit_ping, pm;
   logic [7:0]  ping_expect;
   logic        digits;
   logic [3:0]  dig0, dig1, dig2;
   logic [3:0]  class_kind;
   logic [9:0]  class_value;

   assign pos    = line_pos_ff;
   assign nxt    = (pos >= POS_CAP) ? POS_CAP : pos + 9'd1;
   assign lf_end = (in_byte == ASCII_LF) && cr_ff;

   always_comb begin
      case (ping_ff)
         3'd1:    ping_expect = ASCII_I;
         3'd2:    ping_expect = ASCII_N;
         default: ping_expect = ASCII_G;
      endcase
   end

   // Command classification at the space that ends the command
   assign dig0 = 4'(chars_ff[7:0]   - ASCII_ZERO);
   assign dig1 = 4'(chars_ff[15:8]  - ASCII_ZERO);
   assign dig2 = 4'(chars_ff[23:16] - ASCII_ZERO);
   assign digits = (count_ff == 4'd3)
      && chars_ff[7:0]   >= ASCII_ZERO && chars_ff[7:0]   <= ASCII_NINE
      && chars_ff[15:8]  >= ASCII_ZERO && chars_ff[15:8]  <= ASCII_NINE
      && chars_ff[23:16] >= ASCII_ZERO && chars_ff[23:16] <= ASCII_NINE;

   always_comb begin
      class_value = '0;
      if (digits) begin
         class_kind  = CMD_NUMERIC;
         class_value = 10'(dig0) * 10'd100 + 10'(dig1) * 10'd10 + 10'(dig2);
      end else if (count_ff == 4'd4 && chars_ff == WORD_JOIN)    class_kind = CMD_JOIN;
      else if (count_ff == 4'd4 && chars_ff == WORD_PART)        class_kind = CMD_PART;
      else if (count_ff == 4'd4 && chars_ff == WORD_NICK)        class_kind = CMD_NICK;
      else if (count_ff == 4'd4 && chars_ff == WORD_KICK)        class_kind = CMD_KICK;
      else if (count_ff == 4'd5 && chars_ff == WORD_TOPIC)       class_kind = CMD_TOPIC;
      else if (count_ff == 4'd6 && chars_ff == WORD_NOTICE)      class_kind = CMD_NOTICE;
      else if (count_ff == 4'd7 && chars_ff == WORD_PRIVMSG)     class_kind = CMD_PRIVMSG;
      else class_kind = CMD_UNKNOWN;
   end

   always_comb begin
      phase_in     = phase_ff;
      line_pos_in  = line_pos_ff;
      seg_in       = seg_ff;
      pfx_in       = pfx_ff;
      nick_in      = nick_ff;
      user_in      = user_ff;
      host_in      = host_ff;
      chars_in     = chars_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      numeric_in   = numeric_ff;
      param_in     = param_ff;
      tgt_start_in = tgt_start_ff;
      tgt_len_in   = tgt_len_ff;
      cr_in        = cr_ff;
      ping_in      = ping_ff;
      emit         = 1'b0;
      emit_ping    = 1'b0;
      finish       = 1'b0;
      text_end     = '0;

      if (in_accept) begin
         unique case (phase_ff)
            PH_START: begin
               if (in_byte == ASCII_COLON) begin
                  phase_in = PH_PREFIX;
                  seg_in   = nxt;
               end else if (in_byte == ASCII_P) begin
                  phase_in = PH_PING;
                  ping_in  = 3'd1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_PING: begin
               if (in_byte == ping_expect) begin
                  ping_in = ping_ff + 3'd1;
                  if (ping_in == PING_DONE) begin
                     emit_ping = 1'b1;
                     phase_in  = PH_SKIP;
                  end
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
            end
            PH_PREFIX: begin
               if (lf_end) begin
                  finish = 1'b1;
               end else if (in_byte == ASCII_SPACE) begin
                  if (pfx_ff == PFX_USER) begin
                     host_in = pos - seg_ff;
                  end else begin
                     nick_in = pos - seg_ff;
                     pfx_in  = PFX_SERVER;
                  end
                  seg_in   = nxt;
                  phase_in = PH_COMMAND;
               end else if (pfx_ff == PFX_USER && in_byte == ASCII_AT) begin
                  user_in = pos - seg_ff;
                  seg_in  = nxt;
               end else if (in_byte == ASCII_BANG) begin
                  nick_in = pos - seg_ff;
                  pfx_in  = PFX_USER;
                  seg_in  = nxt;
               end
            end
            PH_COMMAND: begin
               if (lf_end) begin
                  finish = 1'b1;
               end else if (in_byte == ASCII_SPACE) begin
                  kind_in    = class_kind;
                  numeric_in = class_value;
                  seg_in     = nxt;
                  param_in   = 1'b0;
                  phase_in   = PH_TARGET;
               end else begin
                  for (int i = 0; i < CMD_BYTES; i++) begin
                     if (count_ff == 4'(i)) chars_in[8*i +: 8] = in_byte;
                  end
                  if (count_ff < 4'd8) count_in = count_ff + 4'd1;
               end
            end
            PH_TARGET: begin
               if (lf_end) begin
                  emit     = 1'b1;
                  text_end = '0;
                  finish   = 1'b1;
               end else if (in_byte == ASCII_SPACE) begin
                  tgt_start_in = seg_ff;
                  tgt_len_in   = pos - seg_ff;
                  param_in     = 1'b1;
                  phase_in     = PH_COLON;
               end
            end
            PH_COLON: begin
               seg_in   = (in_byte == ASCII_COLON) ? nxt : pos;
               phase_in = PH_TEXT;
            end
            PH_TEXT: begin
               if (lf_end) begin
                  emit     = 1'b1;
                  text_end = pos - 9'd1;
                  finish   = 1'b1;
               end
            end
            default: begin
               phase_in = PH_START;
            end
         endcase

         // buffer end inside the parameters still reports the line
         if (!finish && in_last) begin
            if (phase_in == PH_COLON) seg_in = nxt;
            if (phase_in == PH_TARGET || phase_in == PH_COLON || phase_in == PH_TEXT) begin
               emit     = 1'b1;
               text_end = nxt;
            end
            finish = 1'b1;
         end
      end

      // record built from the updated line state
      pm = (kind_in == CMD_PRIVMSG) && param_in;
      rec_valid         = emit || emit_ping;
      rec.is_ping       = emit_ping;
      rec.prefix_kind   = emit_ping ? PFX_NONE : pfx_in;
      rec.name_len      = emit_ping ? 9'd0 : nick_in;
      rec.user_len      = emit_ping ? 9'd0 : user_in;
      rec.host_len      = emit_ping ? 9'd0 : host_in;
      rec.command_kind  = emit_ping ? CMD_UNKNOWN : kind_in;
      rec.reply_code    = (!emit_ping && kind_in == CMD_NUMERIC) ? numeric_in : 10'd0;
      rec.target_start  = (!emit_ping && pm) ? tgt_start_in : 9'd0;
      rec.target_len    = (!emit_ping && pm) ? tgt_len_in : 9'd0;
      rec.text_start    = (!emit_ping && pm) ? seg_in : 9'd0;
      rec.text_len      = (!emit_ping && pm && text_end > seg_in) ? text_end - seg_in : 9'd0;

      if (in_accept) begin
         if (finish) begin
            phase_in     = PH_START;
            line_pos_in  = '0;
            seg_in       = '0;
            pfx_in       = PFX_NONE;
            nick_in      = '0;
            user_in      = '0;
            host_in      = '0;
            chars_in     = '0;
            count_in     = '0;
            kind_in      = CMD_UNKNOWN;
            numeric_in   = '0;
            param_in     = 1'b0;
            tgt_start_in = '0;
            tgt_len_in   = '0;
            cr_in        = 1'b0;
            ping_in      = '0;
         end else begin
            line_pos_in = nxt;
            cr_in       = (in_byte == ASCII_CR);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         line_pos_ff  <= '0;
         seg_ff       <= '0;
         pfx_ff       <= PFX_NONE;
         nick_ff      <= '0;
         user_ff      <= '0;
         host_ff      <= '0;
         chars_ff     <= '0;
         count_ff     <= '0;
         kind_ff      <= CMD_UNKNOWN;
         numeric_ff   <= '0;
         param_ff     <= 1'b0;
         tgt_start_ff <= '0;
         tgt_len_ff   <= '0;
         cr_ff        <= 1'b0;
         ping_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         line_pos_ff  <= line_pos_in;
         seg_ff       <= seg_in;
         pfx_ff       <= pfx_in;
         nick_ff      <= nick_in;
         user_ff      <= user_in;
         host_ff      <= host_in;
         chars_ff     <= chars_in;
         count_ff     <= count_in;
         kind_ff      <= kind_in;
         numeric_ff   <= numeric_in;
         param_ff     <= param_in;
         tgt_start_ff <= tgt_start_in;
         tgt_len_ff   <= tgt_len_in;
         cr_ff        <= cr_in;
         ping_ff      <= ping_in;
      end
   end

endmodule

FILE: rtl/irclp_out_buf.sv
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register.
// Depends on irclp_pkg.
module irclp_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  irclp_pkg::rec_type in_rec,
   output logic               in_ready,
   output logic               out_valid,
   output irclp_pkg::rec_type out_rec,
   input  logic               out_ready
);
   import irclp_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rec_type main_ff, main_in;
   rec_type skid_ff, skid_in;
   logic    take;

   assign take      = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_rec   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || take) begin
            main_in       = in_rec;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_rec;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: rtl/irc_line_parser_core.sv
`timescale 1ns / 1ps
// Top level of the IRC line parser: byte stream in, one record per parsed line out.
// Depends on irclp_pkg, irclp_parser and irclp_out_buf.

// The core takes one received byte per request on the req_ side, with req_tlast
// marking the last byte of a receive buffer, and sustains one byte per clock
// while req_tready is high. Each byte is folded into the line state in the same
// cycle it is accepted; a record (line summary, or a ping record flagged on
// rsp_tuser) enters the result buffer on the byte that completes it: the G of
// PING, the LF of a CR LF pair or the buffer's last byte while in the parameters.
// Lines starting with neither ':' nor "PING", and lines cut off in the prefix or
// command, give no record. Offsets and lengths count from the start of the line
// and saturate at the smaller of MAX_LINE-1 and 511. Results go through a
// two-entry buffer, so byte intake continues while one record waits; req_tready
// falls only when both entries are held, and is a register output.
module irc_line_parser_core #(
   parameter int MAX_LINE = 512
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // buffer_end
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] prefix_kind, [10:2] name_len, [19:11] user_len, [28:20] host_len,
   // [32:29] command_kind, [42:33] reply_code, [51:43] target_start,
   // [60:52] target_len, [69:61] text_start, [78:70] text_len, [79] zero
   output logic [79:0] rsp_tdata,
   output logic        rsp_tuser    // [0] is_ping
);
   import irclp_pkg::*;

   logic    req_accept;
   logic    rec_valid;
   rec_type rec;
   rec_type out_rec;

   assign req_accept = req_tvalid && req_tready;

   irclp_parser #(
      .MAX_LINE (MAX_LINE)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   irclp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rec_valid),
      .in_rec    (rec),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_rec   (out_rec),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, out_rec.text_len, out_rec.text_start, out_rec.target_len,
                       out_rec.target_start, out_rec.reply_code, out_rec.command_kind,
                       out_rec.host_len, out_rec.user_len, out_rec.name_len,
                       out_rec.prefix_kind};
   assign rsp_tuser = out_rec.is_ping;

endmodule

FILE: tb/irc_line_parser_checker.sv
`timescale 1ns / 1ps
// Scoreboard for irc_line_parser_core: follows every accepted request byte, predicts the
// line records and compares them with the result channel. Depends on irclp_pkg.
module irc_line_parser_checker #(
   parameter int MAX_LINE = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          mismatches,
   output int          outstanding,
   output int          records_checked,
   output int          pings_checked,
   output int          privmsgs_checked
);
   import irclp_pkg::*;

   localparam logic [8:0] POS_CAP = (MAX_LINE - 1 > 511) ? 9'd511 : 9'(MAX_LINE - 1);
   localparam int MAX_REPORTS = 40;

   // predicted line state
   phase_type   ph;
   logic [8:0]  line_pos, seg_start;
   logic [1:0]  pfx_kind;
   logic [8:0]  nick_len, user_len, host_len;
   logic [55:0] cmd_chars;
   logic [3:0]  cmd_count, cmd_kind;
   logic [9:0]  reply_val;
   logic        have_target;
   logic [8:0]  tgt_start, tgt_len;
   logic        saw_cr;
   logic [2:0]  ping_count;

   rec_type line_records[$];
   int err_count = 0;
   int n_records = 0, n_pings = 0, n_privmsgs = 0;

   function automatic void restart_line();
      ph = PH_START;
      line_pos = '0; seg_start = '0; pfx_kind = PFX_NONE;
      nick_len = '0; user_len = '0; host_len = '0;
      cmd_chars = '0; cmd_count = '0; cmd_kind = CMD_UNKNOWN; reply_val = '0;
      have_target = 1'b0; tgt_start = '0; tgt_len = '0;
      saw_cr = 1'b0; ping_count = '0;
   endfunction

   function automatic logic digit_ok(logic [7:0] c);
      return c >= ASCII_ZERO && c <= ASCII_NINE;
   endfunction

   function automatic void classify_command();
      logic [7:0] c0, c1, c2;
      int value;
      c0 = cmd_chars[7:0];
      c1 = cmd_chars[15:8];
      c2 = cmd_chars[23:16];
      cmd_kind = CMD_UNKNOWN;
      reply_val = '0;
      if (cmd_count == 4'd3 && digit_ok(c0) && digit_ok(c1) && digit_ok(c2)) begin
         value = (int'(c0) - int'(ASCII_ZERO)) * 100 + (int'(c1) - int'(ASCII_ZERO)) * 10
               + (int'(c2) - int'(ASCII_ZERO));
         cmd_kind = CMD_NUMERIC;
         reply_val = 10'(value);
      end else if (cmd_count == 4'd4 && cmd_chars == WORD_JOIN)    cmd_kind = CMD_JOIN;
      else if (cmd_count == 4'd4 && cmd_chars == WORD_PART)       cmd_kind = CMD_PART;
      else if (cmd_count == 4'd4 && cmd_chars == WORD_NICK)       cmd_kind = CMD_NICK;
      else if (cmd_count == 4'd4 && cmd_chars == WORD_KICK)       cmd_kind = CMD_KICK;
      else if (cmd_count == 4'd5 && cmd_chars == WORD_TOPIC)      cmd_kind = CMD_TOPIC;
      else if (cmd_count == 4'd6 && cmd_chars == WORD_NOTICE)     cmd_kind = CMD_NOTICE;
      else if (cmd_count == 4'd7 && cmd_chars == WORD_PRIVMSG)    cmd_kind = CMD_PRIVMSG;
   endfunction

   // Target and text fields only count for a PRIVMSG whose target space was seen.
   function automatic rec_type line_record(int text_end);
      rec_type r;
      logic    with_text;
      r = '0;
      with_text = (cmd_kind == CMD_PRIVMSG) && have_target;
      r.prefix_kind  = pfx_kind;
      r.name_len     = nick_len;
      r.user_len     = user_len;
      r.host_len     = host_len;
      r.command_kind = cmd_kind;
      r.reply_code   = (cmd_kind == CMD_NUMERIC) ? reply_val : '0;
      if (with_text) begin
         r.target_start = tgt_start;
         r.target_len   = tgt_len;
         r.text_start   = seg_start;
         if (text_end > int'(seg_start))
            r.text_len = 9'(text_end - int'(seg_start));
      end
      return r;
   endfunction

   function automatic void take_byte(logic [7:0] b, logic is_last);
      logic [8:0] pos, nxt;
      logic       lf_end, done;
      rec_type    ping_rec;
      pos = line_pos;
      nxt = (pos >= POS_CAP) ? POS_CAP : pos + 9'd1;
      lf_end = (b == ASCII_LF) && saw_cr;
      done = 1'b0;
      case (ph)
         PH_START: begin
            if (b == ASCII_COLON) begin
               ph = PH_PREFIX;
               seg_start = nxt;
            end else if (b == ASCII_P) begin
               ph = PH_PING;
               ping_count = 3'd1;
            end else
               ph = PH_SKIP;
         end
         PH_PING: begin
            if ((ping_count == 3'd1 && b == ASCII_I) || (ping_count == 3'd2 && b == ASCII_N) ||
                (ping_count == 3'd3 && b == ASCII_G)) begin
               ping_count = ping_count + 3'd1;
               if (ping_count == PING_DONE) begin
                  ping_rec = '0;
                  ping_rec.is_ping = 1'b1;
                  line_records.push_back(ping_rec);
                  ph = PH_SKIP;
               end
            end else
               ph = PH_SKIP;
         end
         PH_SKIP: ;
         PH_PREFIX: begin
            if (lf_end)
               done = 1'b1;
            else if (b == ASCII_SPACE) begin
               if (pfx_kind == PFX_USER)
                  host_len = pos - seg_start;
               else begin
                  nick_len = pos - seg_start;
                  pfx_kind = PFX_SERVER;
               end
               seg_start = nxt;
               ph = PH_COMMAND;
            end else if (pfx_kind == PFX_USER && b == ASCII_AT) begin
               user_len = pos - seg_start;
               seg_start = nxt;
            end else if (b == ASCII_BANG) begin
               nick_len = pos - seg_start;
               pfx_kind = PFX_USER;
               seg_start = nxt;
            end
         end
         PH_COMMAND: begin
            if (lf_end)
               done = 1'b1;
            else if (b == ASCII_SPACE) begin
               classify_command();
               seg_start = nxt;
               have_target = 1'b0;
               ph = PH_TARGET;
            end else begin
               if (cmd_count < 4'd7) cmd_chars[8 * cmd_count +: 8] = b;
               if (cmd_count < 4'd8) cmd_count = cmd_count + 4'd1;
            end
         end
         PH_TARGET: begin
            if (lf_end) begin
               line_records.push_back(line_record(0));
               done = 1'b1;
            end else if (b == ASCII_SPACE) begin
               tgt_start = seg_start;
               tgt_len = pos - seg_start;
               have_target = 1'b1;
               ph = PH_COLON;
            end
         end
         PH_COLON: begin
            seg_start = (b == ASCII_COLON) ? nxt : pos;
            ph = PH_TEXT;
         end
         default: begin  // text
            if (lf_end) begin
               line_records.push_back(line_record(int'(pos) - 1));
               done = 1'b1;
            end
         end
      endcase

      // buffer end inside the parameters still closes the record
      if (!done && is_last) begin
         if (ph == PH_COLON) seg_start = nxt;
         if (ph == PH_TARGET || ph == PH_COLON || ph == PH_TEXT)
            line_records.push_back(line_record(int'(nxt)));
         done = 1'b1;
      end

      if (done || is_last)
         restart_line();
      else begin
         line_pos = nxt;
         saw_cr = (b == ASCII_CR);
      end
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         err_count++;
         if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rec_type want, got;
      if (reset) begin
         restart_line();
         line_records.delete();
      end else begin
         if (req_tvalid && req_tready)
            take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = rec_type'(rsp_tdata);
            got.is_ping = rsp_tuser;
            if (line_records.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display("%0t: record with none expected, expected nothing, got tdata %h tuser %b",
                           $time, rsp_tdata, rsp_tuser);
            end else begin
               want = line_records.pop_front();
               check_field("prefix_kind",  16'(want.prefix_kind),  16'(got.prefix_kind));
               check_field("name_len",     16'(want.name_len),     16'(got.name_len));
               check_field("user_len",     16'(want.user_len),     16'(got.user_len));
               check_field("host_len",     16'(want.host_len),     16'(got.host_len));
               check_field("command_kind", 16'(want.command_kind), 16'(got.command_kind));
               check_field("reply_code",   16'(want.reply_code),   16'(got.reply_code));
               check_field("target_start", 16'(want.target_start), 16'(got.target_start));
               check_field("target_len",   16'(want.target_len),   16'(got.target_len));
               check_field("text_start",   16'(want.text_start),   16'(got.text_start));
               check_field("text_len",     16'(want.text_len),     16'(got.text_len));
               check_field("is_ping",      16'(want.is_ping),      16'(got.is_ping));
               check_field("tdata[79]",    16'(1'b0),              16'(rsp_tdata[79]));
               n_records++;
               if (want.is_ping) n_pings++;
               if (want.command_kind == CMD_PRIVMSG) n_privmsgs++;
            end
         end
      end
      mismatches       <= err_count;
      outstanding      <= line_records.size();
      records_checked  <= n_records;
      pings_checked    <= n_pings;
      privmsgs_checked <= n_privmsgs;
   end

endmodule

FILE: tb/irc_line_parser_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for irc_line_parser_core: drives IRC byte streams with random gaps and
// back-pressure, and gives the verdict. Depends on irclp_pkg and irc_line_parser_checker.
module irc_line_parser_core_tb;
   import irclp_pkg::*;

   // how a line ends: CR LF inside the buffer, CR LF as the buffer's last bytes,
   // or the buffer simply ending on the line's last byte
   localparam int TERM_CRLF      = 0;
   localparam int TERM_CRLF_LAST = 1;
   localparam int TERM_LAST      = 2;

   // request bytes over the whole run, directed lines included
   localparam int BYTE_BUDGET = 1850;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;

   int mismatches, outstanding, records_checked, pings_checked, privmsgs_checked;

   bit         no_idle = 1'b0;   // burst stretch: no gaps and no stalls
   int         stall_left = 0;
   logic [7:0] line_q[$];        // bytes of the line being built
   int         parsed_bytes = 0, bytes_sent = 0, lines_sent = 0;

   string cmd_words[6] = '{"JOIN", "PART", "NICK", "KICK", "TOPIC", "NOTICE"};

   irc_line_parser_core #(.MAX_LINE(512)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   irc_line_parser_checker #(.MAX_LINE(512)) scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .records_checked  (records_checked),
      .pings_checked    (pings_checked),
      .privmsgs_checked (privmsgs_checked)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Gap length in cycles: mostly none or short, now and then long.
   function automatic int gap_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Result side: random stalls, long ones rare; none during a burst stretch.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!reset && !no_idle && $urandom_range(0, 7) == 0) begin
         stall_left = gap_cycles();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // One request byte; valid stays high across back-to-back bytes.
   task automatic send_byte(logic [7:0] b, logic is_last);
      int gap;
      gap = no_idle ? 0 : gap_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_line(bit end_buffer, bit parsed);
      int n;
      n = line_q.size();
      for (int i = 0; i < n; i++)
         send_byte(line_q[i], end_buffer && i == n - 1);
      if (parsed) parsed_bytes += n;
      bytes_sent += n;
      lines_sent++;
      line_q.delete();
   endtask

   task automatic put(string s);
      for (int i = 0; i < s.len(); i++)
         line_q.push_back(s[i]);
   endtask

   task automatic put_crlf();
      line_q.push_back(ASCII_CR);
      line_q.push_back(ASCII_LF);
   endtask

   task automatic say(string s, int term);
      put(s);
      if (term != TERM_LAST) put_crlf();
      send_line(term != TERM_CRLF, s.len() > 0 && s[0] == ASCII_COLON);
   endtask

   function automatic logic [7:0] name_char();
      string pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.[]{}|";
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   // Text is mostly printable, with spaces, colons and now and then any byte at all
   // (which may be a lone CR or LF, or even a CR LF that ends the line early).
   function automatic logic [7:0] text_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 84) return 8'($urandom_range(8'h21, 8'h7E));
      if (pick < 92) return ASCII_SPACE;
      if (pick < 95) return ASCII_COLON;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic put_name(int lo, int hi);
      repeat ($urandom_range(lo, hi)) line_q.push_back(name_char());
   endtask

   // A prefixed line: prefix, command, parameters, then one of the ways a line ends,
   // including being cut off anywhere.
   task automatic colon_line(output int term);
      int pick, n;
      put(":");
      pick = $urandom_range(0, 99);
      if (pick < 35)
         put_name(1, 16);                                   // server name
      else if (pick < 75) begin                            // nick!user@host
         put_name(1, 9);
         line_q.push_back(ASCII_BANG);
         put_name(1, 9);
         line_q.push_back(ASCII_AT);
         put_name(1, 20);
      end else if (pick < 85) begin                        // nick!user, maybe empty parts
         put_name(0, 9);
         line_q.push_back(ASCII_BANG);
         put_name(0, 9);
      end else if (pick < 95) begin                        // separators in any order
         repeat ($urandom_range(1, 6)) begin
            put_name(0, 4);
            line_q.push_back($urandom_range(0, 1) ? ASCII_BANG : ASCII_AT);
         end
         put_name(0, 4);
      end                                                  // else empty prefix
      line_q.push_back(ASCII_SPACE);

      pick = $urandom_range(0, 99);
      if (pick < 35)
         put("PRIVMSG");
      else if (pick < 63)
         put(cmd_words[$urandom_range(0, 5)]);
      else if (pick < 76)
         repeat (3) line_q.push_back(8'($urandom_range(ASCII_ZERO, ASCII_NINE)));
      else if (pick < 82)
         put("privmsg");
      else if (pick < 90)
         repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
      else if (pick < 95)   // digit-like, just outside the digits too, odd lengths
         repeat ($urandom_range(1, 5))
            line_q.push_back(8'($urandom_range(ASCII_ZERO - 1, ASCII_NINE + 1)));
      else
         repeat ($urandom_range(1, 9)) line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));

      if ($urandom_range(0, 9) != 0) begin
         line_q.push_back(ASCII_SPACE);
         put_name(0, 12);
         if ($urandom_range(0, 6) != 0) begin
            line_q.push_back(ASCII_SPACE);
            if ($urandom_range(0, 9) < 7) line_q.push_back(ASCII_COLON);
            // rarely a line long enough to saturate the offsets
            n = ($urandom_range(0, 79) == 0) ? $urandom_range(470, 560) : $urandom_range(0, 30);
            repeat (n) line_q.push_back(text_char());
         end
      end

      pick = $urandom_range(0, 99);
      if (pick < 68) begin
         put_crlf();
         term = TERM_CRLF;
      end else if (pick < 78) begin
         put_crlf();
         term = TERM_CRLF_LAST;
      end else if (pick < 90)
         term = TERM_LAST;
      else begin
         n = $urandom_range(1, line_q.size() - 1);
         while (line_q.size() > n) void'(line_q.pop_back());
         if ($urandom_range(0, 1)) begin
            put_crlf();
            term = TERM_CRLF;
         end else
            term = TERM_LAST;
      end
   endtask

   // Lines the parser drops the rest of the buffer for: PING, near misses, other starts.
   task automatic skip_line();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         put("PING");
         if ($urandom_range(0, 1)) put(" :");
         put_name(0, 10);
         put_crlf();
      end else if (pick < 60) begin
         case ($urandom_range(0, 3))
            0: put("PONG");
            1: put("PIN");
            2: put("PI");
            default: put("P");
         endcase
      end else
         line_q.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 6)) line_q.push_back(text_char());
      send_line(1'b1, 1'b0);
   endtask

   initial begin
      int term;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed lines ----
      // numeric replies, digit edges and non-numeric near misses
      say(":irc.example.org 001 me :Welcome", TERM_CRLF);
      say(":srv 000 a", TERM_CRLF);
      say(":srv 999 b", TERM_CRLF);
      say(":srv 12A c", TERM_CRLF);
      say(":srv 1234 d", TERM_CRLF);
      // every named command with a full user prefix
      say(":nick!user@host PRIVMSG #chan :hello there", TERM_CRLF);
      say(":n!u@h JOIN #c", TERM_CRLF);
      say(":n!u@h PART #c :bye", TERM_CRLF);
      say(":n!u@h NICK :other", TERM_CRLF);
      say(":n!u@h KICK #c x :out", TERM_CRLF);
      say(":n!u@h TOPIC #c :topic", TERM_CRLF);
      say(":n!u@h NOTICE me :hi", TERM_CRLF);
      // several separators, empty target, empty prefix
      say(":x!y@z@w!v PRIVMSG  :", TERM_CRLF);
      say(": PART #x", TERM_CRLF);
      // buffer ends in text without colon, on the target space, after the colon, in target
      say(":a!b PRIVMSG bob plain text", TERM_LAST);
      say(":a PRIVMSG t ", TERM_LAST);
      say(":a PRIVMSG t :", TERM_LAST);
      say(":a PRIVMSG tgt", TERM_LAST);
      // LF that closes the line is also the buffer's last byte
      say(":a PRIVMSG t :x", TERM_CRLF_LAST);
      // lines cut in the prefix and in the command, long commands
      say(":abc", TERM_CRLF);
      say(":a JOI", TERM_CRLF);
      say(":a PRIVMSGS t :x", TERM_CRLF);
      say(":a ABCDEFGHIJ t", TERM_CRLF);
      // lone CR and lone LF inside the text
      put(":a PRIVMSG t :x");
      line_q.push_back(ASCII_CR);
      put("y");
      line_q.push_back(ASCII_LF);
      put("z");
      put_crlf();
      send_line(1'b0, 1'b1);
      // byte extremes in the text
      put(":a PRIVMSG t :");
      line_q.push_back(8'h00);
      line_q.push_back(8'hFF);
      line_q.push_back(8'h80);
      line_q.push_back(8'h7F);
      put_crlf();
      send_line(1'b1, 1'b1);
      // PING; the prefixed line after it in the same buffer is ignored
      put("PING :srv");
      put_crlf();
      put(":a JOIN #c");
      put_crlf();
      send_line(1'b1, 1'b0);
      say("PONG :x", TERM_CRLF_LAST);
      say("PIN", TERM_LAST);
      say("NOTICE x", TERM_CRLF_LAST);
      say("", TERM_CRLF_LAST);
      // long text and long prefix: offsets saturate
      put(":n!u@h PRIVMSG #c :");
      repeat (500) line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      put_crlf();
      send_line(1'b0, 1'b1);
      put(":");
      repeat (515) line_q.push_back(name_char());
      put(" PRIVMSG t :hi");
      put_crlf();
      send_line(1'b0, 1'b1);

      // ---- random lines ----
      while (bytes_sent < BYTE_BUDGET) begin
         no_idle = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) < 8) begin
            colon_line(term);
            send_line(term != TERM_CRLF, 1'b1);
         end else
            skip_line();
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      // drain: records trail their last byte and may sit in the output buffer
      repeat (20) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Drove %0d bytes (%0d in prefixed lines) in %0d lines, with back-pressure",
               bytes_sent, parsed_bytes, lines_sent);
      $display("and idle gaps on both sides; checked %0d records (%0d ping, %0d PRIVMSG), %0d field mismatches.",
               records_checked, pings_checked, privmsgs_checked, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("** irc_line_parser_core: PASSED **");
      else
         $display("** irc_line_parser_core: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #(3_000_000);
      $display("Timeout with %0d records still expected.", outstanding);
      $display("** irc_line_parser_core: FAILED **");
      $finish;
   end

endmodule
